/* hdl/abdn_pkg.sv */
`default_nettype none
package abdn_pkg;

  localparam int NUM_W = 50;
  localparam int DEN_W = 34;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int MA_W = 36;
  localparam int MB_W = 33;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic signed [15:0] LOGIT_POS = 16'sd4096;
  localparam logic signed [15:0] LOGIT_NEG = -16'sd4096;
  localparam logic [33:0] TINY_UNION = 34'd5;
  localparam logic signed [35:0] ONE_Q16 = 36'sd65536;
  localparam logic [6:0] MAX_OUT = 7'd64;
  localparam logic [3:0] TAYLOR_TERMS = 4'd12;

  localparam logic [2:0] CFG_SCORE_THR = 3'd0;
  localparam logic [2:0] CFG_IOU_THR = 3'd1;
  localparam logic [2:0] CFG_MAX_DET = 3'd2;
  localparam logic [2:0] CFG_X_SCALE = 3'd3;
  localparam logic [2:0] CFG_Y_SCALE = 3'd4;
  localparam logic [2:0] CFG_W_SCALE = 3'd5;
  localparam logic [2:0] CFG_H_SCALE = 3'd6;

endpackage
`default_nettype wire

/* hdl/abdn_mul.sv */
`default_nettype none
module abdn_mul (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [abdn_pkg::MA_W-1:0] a,
  input  wire logic [abdn_pkg::MB_W-1:0] b,
  output logic      [abdn_pkg::MP_W-1:0] p
);
  import abdn_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MP_W'(a) * MP_W'(b);
    end
  end

endmodule
`default_nettype wire

/* hdl/abdn_div.sv */
`default_nettype none
module abdn_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [abdn_pkg::NUM_W-1:0] num,
  input  wire logic [abdn_pkg::DEN_W-1:0] den,
  output logic                            done,
  output logic      [abdn_pkg::NUM_W-1:0] quo
);
  import abdn_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dn;
  logic [DEN_W:0]   sh;
  logic             ge;

  assign sh = {rem, quo[NUM_W-1]};
  assign ge = sh >= {1'b0, dn};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
        quo <= num;
        rem <= '0;
        dn <= den;
      end else if (busy) begin
        rem <= ge ? DEN_W'(sh - {1'b0, dn}) : DEN_W'(sh);
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/anchor_box_decode_weighted_nms.sv */
`default_nettype none
// All divides share one divider. An anchor whose logit lies within plus or minus 16
// runs twelve series terms and the score quotient through it; a clipped logit skips
// the series, and a score that passes the threshold adds four box deltas. Insertion
// shifts lower-scored entries down one place at a time. A frame end then runs NMS,
// with four divides per merged box. Reset is synchronous and clears control state.
module anchor_box_decode_weighted_nms #(
  parameter int MAX_CAND = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] score_logit,
  input  wire logic signed [19:0] delta_y,
  input  wire logic signed [19:0] delta_x,
  input  wire logic signed [19:0] delta_h,
  input  wire logic signed [19:0] delta_w,
  input  wire logic [16:0]        anchor_x,
  input  wire logic [16:0]        anchor_y,
  input  wire logic [17:0]        anchor_w,
  input  wire logic [17:0]        anchor_h,
  input  wire logic               frame_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [16:0]             box_x,
  output logic [16:0]             box_y,
  output logic [16:0]             box_w,
  output logic [16:0]             box_h,
  output logic [15:0]             peak_score,
  output logic                    last_box,
  output logic                    empty_frame,
  output logic                    overflow
);
  import abdn_pkg::*;

  localparam int AW = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
  localparam int CW = $clog2(MAX_CAND + 1);
  localparam int SUM_W = 33 + CW;
  localparam int SW_W = 16 + CW;
  localparam logic [CW-1:0] CAND_FULL = CW'(MAX_CAND);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CAND - 1);

  typedef struct packed {
    logic [16:0] l;
    logic [16:0] t;
    logic [16:0] w;
    logic [16:0] h;
    logic [15:0] s;
  } cand_t;

  typedef enum logic [28:0] {
    S_IDLE = 29'h0000001,
    S_SG0  = 29'h0000002,
    S_SG1  = 29'h0000004,
    S_SG2  = 29'h0000008,
    S_SG3  = 29'h0000010,
    S_SG4  = 29'h0000020,
    S_CHK  = 29'h0000040,
    S_DCM  = 29'h0000080,
    S_DCD  = 29'h0000100,
    S_GEOM = 29'h0000200,
    S_INS0 = 29'h0000400,
    S_INSF = 29'h0000800,
    S_INSR = 29'h0001000,
    S_INSC = 29'h0002000,
    S_FE   = 29'h0004000,
    S_NMI  = 29'h0008000,
    S_NML  = 29'h0010000,
    S_NMAR = 29'h0020000,
    S_ACCM = 29'h0040000,
    S_ACCA = 29'h0080000,
    S_NMJ  = 29'h0100000,
    S_NMB  = 29'h0200000,
    S_NMB1 = 29'h0400000,
    S_NMB2 = 29'h0800000,
    S_NMB3 = 29'h1000000,
    S_NMO  = 29'h2000000,
    S_NMDV = 29'h4000000,
    S_NMP  = 29'h8000000,
    S_FIN  = 29'h10000000
  } state_t;

  state_t state;

  logic [15:0] score_thr, iou_thr;
  logic [6:0]  max_det;
  logic [12:0] x_sc, y_sc, w_sc, h_sc;

  logic signed [15:0] logit;
  logic signed [19:0] dlt [4];
  logic [16:0] ax, ay;
  logic [17:0] aw, ah;
  logic        fend;

  logic [5:0]  nsh;
  logic [31:0] gval;
  logic [32:0] sum;
  logic [3:0]  kk;
  logic [15:0] score;
  logic [1:0]  dsel;
  logic signed [31:0] dq [4];
  cand_t       nb;

  logic [AW-1:0] kidx;
  logic [CW-1:0] count;
  logic          ovf;

  logic [MAX_CAND-1:0] mask;
  logic [CW-1:0] ii, jj;
  logic [6:0]    nout;
  cand_t         lead, cur, res, pend;
  logic          pend_v;
  logic [32:0]   area_a, area_b;
  logic [34:0]   inter;
  logic [33:0]   uni;
  logic [1:0]    csel;
  logic [SUM_W-1:0] sums [4];
  logic [SW_W-1:0]  sw;
  logic          dpend;

  cand_t cand_mem [MAX_CAND];
  cand_t rd_q;
  logic  [AW-1:0] rd_addr, mem_wa;
  cand_t mem_wd;
  logic  mem_we;

  logic            mul_en;
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] mul_p;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_q;
  logic [DEN_W-1:0] div_den;

  logic [15:0] mag16;
  logic        in_range;
  logic [32:0] e_c;
  logic [33:0] den_c;
  logic [12:0] sel_sc, sc_eff;
  logic [17:0] sel_sz;
  logic [19:0] dmag;
  logic [31:0] dq_mag;
  logic [6:0]  limit;
  logic        out_free;
  logic        out_load;

  logic signed [35:0] dx36, dy36, dw36, dh36, hw_w, hh_w;
  logic signed [35:0] l_w, r_w, t_w, b_w, lc, rc, tc, bc, wv, hv;
  logic        box_ok;

  logic [17:0] lx2, cx2, ly2, cy2;
  logic [16:0] ix1, iy1;
  logic [17:0] ix2, iy2;
  logic [18:0] iw_s, ih_s;
  logic [17:0] iwc, ihc;
  logic [34:0] uni_w;
  logic [16:0] cur_coord;
  logic        merge;

  abdn_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  abdn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == S_NMP) && pend_v && out_free) ||
                    ((state == S_FIN) && out_free);

  assign mag16 = logit[15] ? 16'(-logit) : 16'(logit);
  assign in_range = (logit >= LOGIT_NEG) && (logit <= LOGIT_POS);
  assign e_c = sum >> nsh;
  assign den_c = 34'h1_0000_0000 + 34'(e_c);

  always_comb begin
    unique case (dsel)
      2'd0: begin sel_sc = y_sc; sel_sz = ah; end
      2'd1: begin sel_sc = x_sc; sel_sz = aw; end
      2'd2: begin sel_sc = h_sc; sel_sz = ah; end
      default: begin sel_sc = w_sc; sel_sz = aw; end
    endcase
  end

  assign sc_eff = (sel_sc == 13'd0) ? 13'd1 : sel_sc;
  assign dmag = dlt[dsel][19] ? 20'(-dlt[dsel]) : 20'(dlt[dsel]);
  assign dq_mag = {1'b0, div_q[30:0]};

  assign limit = (max_det == 7'd0) ? 7'd1 : ((max_det > MAX_OUT) ? MAX_OUT : max_det);

  assign dy36 = {{4{dq[0][31]}}, dq[0]};
  assign dx36 = {{4{dq[1][31]}}, dq[1]};
  assign dh36 = {{4{dq[2][31]}}, dq[2]};
  assign dw36 = {{4{dq[3][31]}}, dq[3]};
  assign hw_w = $signed(dw36 + 36'(dw36[35])) >>> 1;
  assign hh_w = $signed(dh36 + 36'(dh36[35])) >>> 1;
  assign l_w = $signed({19'b0, ax}) + dx36 - hw_w;
  assign r_w = l_w + dw36;
  assign t_w = $signed({19'b0, ay}) + dy36 - hh_w;
  assign b_w = t_w + dh36;
  assign lc = l_w[35] ? '0 : l_w;
  assign tc = t_w[35] ? '0 : t_w;
  assign rc = (r_w > ONE_Q16) ? ONE_Q16 : r_w;
  assign bc = (b_w > ONE_Q16) ? ONE_Q16 : b_w;
  assign wv = rc - lc;
  assign hv = bc - tc;
  assign box_ok = !wv[35] && (wv != '0) && !hv[35] && (hv != '0);

  assign lx2 = {1'b0, lead.l} + {1'b0, lead.w};
  assign cx2 = {1'b0, cur.l} + {1'b0, cur.w};
  assign ly2 = {1'b0, lead.t} + {1'b0, lead.h};
  assign cy2 = {1'b0, cur.t} + {1'b0, cur.h};
  assign ix1 = (lead.l > cur.l) ? lead.l : cur.l;
  assign iy1 = (lead.t > cur.t) ? lead.t : cur.t;
  assign ix2 = (lx2 < cx2) ? lx2 : cx2;
  assign iy2 = (ly2 < cy2) ? ly2 : cy2;
  assign iw_s = {1'b0, ix2} - {2'b0, ix1};
  assign ih_s = {1'b0, iy2} - {2'b0, iy1};
  assign iwc = iw_s[18] ? '0 : iw_s[17:0];
  assign ihc = ih_s[18] ? '0 : ih_s[17:0];
  assign uni_w = 35'(area_a) + 35'(area_b) - mul_p[34:0];
  assign merge = (uni < TINY_UNION) ? (iou_thr == 16'd0)
                                    : ({inter, 16'b0} >= {1'b0, mul_p[49:0]});

  always_comb begin
    unique case (csel)
      2'd0: cur_coord = cur.l;
      2'd1: cur_coord = cur.t;
      2'd2: cur_coord = cur.w;
      default: cur_coord = cur.h;
    endcase
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_num = '0;
    div_den = DEN_W'(1);
    mem_we = 1'b0;
    mem_wa = kidx;
    mem_wd = nb;
    rd_addr = ii[AW-1:0];
    unique case (state)
      S_SG0: begin
        mul_en = in_range;
        mul_a = MA_W'(mag16[12:0]);
        mul_b = MB_W'(LOG2E_Q24);
      end
      S_SG1: begin
        mul_en = 1'b1;
        mul_a = MA_W'(mul_p[31:0]);
        mul_b = MB_W'(LN2_Q32);
      end
      S_SG2: begin
        mul_en = 1'b1;
        mul_a = MA_W'(36'h1_0000_0000);
        mul_b = MB_W'(mul_p[63:32]);
      end
      S_SG3: begin
        div_start = !dpend;
        div_num = NUM_W'(mul_p[64:32]);
        div_den = DEN_W'(kk);
        mul_en = div_done && (kk != TAYLOR_TERMS);
        mul_a = MA_W'(div_q[32:0]);
        mul_b = MB_W'(gval);
      end
      S_SG4: begin
        div_start = !dpend;
        div_den = den_c;
        if (logit[15]) begin
          div_num = (NUM_W'(e_c) << 16) + NUM_W'(den_c >> 1);
        end else begin
          div_num = (NUM_W'(1) << 48) + NUM_W'(den_c >> 1);
        end
      end
      S_DCM: begin
        mul_en = 1'b1;
        mul_a = MA_W'(dmag);
        mul_b = MB_W'(sel_sz);
      end
      S_DCD: begin
        div_start = !dpend;
        div_num = NUM_W'(mul_p[37:0]) + NUM_W'({sc_eff, 7'b0});
        div_den = DEN_W'({sc_eff, 8'b0});
      end
      S_INS0: rd_addr = LAST_ADDR;
      S_INSR: begin
        mem_we = (kidx == '0);
        rd_addr = kidx - 1'b1;
      end
      S_INSC: begin
        mem_we = 1'b1;
        mem_wd = (rd_q.s >= nb.s) ? nb : rd_q;
      end
      S_NML: begin
        mul_en = 1'b1;
        mul_a = MA_W'(rd_q.w);
        mul_b = MB_W'(rd_q.h);
      end
      S_ACCM: begin
        mul_en = 1'b1;
        mul_a = MA_W'(cur_coord);
        mul_b = MB_W'(cur.s);
      end
      S_NMJ: rd_addr = jj[AW-1:0];
      S_NMB: begin
        mul_en = 1'b1;
        mul_a = MA_W'(rd_q.w);
        mul_b = MB_W'(rd_q.h);
      end
      S_NMB1: begin
        mul_en = 1'b1;
        mul_a = MA_W'(iwc);
        mul_b = MB_W'(ihc);
      end
      S_NMB2: begin
        mul_en = 1'b1;
        mul_a = MA_W'(uni_w[33:0]);
        mul_b = MB_W'(iou_thr);
      end
      S_NMDV: begin
        div_start = !dpend;
        div_num = NUM_W'(sums[csel]) + NUM_W'(sw >> 1);
        div_den = DEN_W'(sw);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cand_mem[mem_wa] <= mem_wd;
    end
    rd_q <= cand_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      score_thr <= 16'd32768;
      iou_thr <= 16'd19661;
      max_det <= 7'd1;
      x_sc <= 13'd128;
      y_sc <= 13'd128;
      w_sc <= 13'd128;
      h_sc <= 13'd128;
      dpend <= 1'b0;
      count <= '0;
      ovf <= 1'b0;
      mask <= '0;
      pend_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SCORE_THR: score_thr <= cfg_data;
          CFG_IOU_THR:   iou_thr <= cfg_data;
          CFG_MAX_DET:   max_det <= cfg_data[6:0];
          CFG_X_SCALE:   x_sc <= cfg_data[12:0];
          CFG_Y_SCALE:   y_sc <= cfg_data[12:0];
          CFG_W_SCALE:   w_sc <= cfg_data[12:0];
          CFG_H_SCALE:   h_sc <= cfg_data[12:0];
          default: ;
        endcase
      end

      if (div_start) begin
        dpend <= 1'b1;
      end else if (div_done) begin
        dpend <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            logit <= score_logit;
            dlt[0] <= delta_y;
            dlt[1] <= delta_x;
            dlt[2] <= delta_h;
            dlt[3] <= delta_w;
            ax <= anchor_x;
            ay <= anchor_y;
            aw <= anchor_w;
            ah <= anchor_h;
            fend <= frame_end;
            state <= S_SG0;
          end
        end
        S_SG0: begin
          if (in_range) begin
            state <= S_SG1;
          end else begin
            score <= logit[15] ? 16'd0 : 16'hFFFF;
            state <= S_CHK;
          end
        end
        S_SG1: begin
          nsh <= mul_p[37:32];
          state <= S_SG2;
        end
        S_SG2: begin
          gval <= mul_p[63:32];
          sum <= 33'h1_0000_0000;
          kk <= 4'd1;
          state <= S_SG3;
        end
        S_SG3: begin
          if (div_done) begin
            sum <= kk[0] ? (sum - div_q[32:0]) : (sum + div_q[32:0]);
            if (kk == TAYLOR_TERMS) begin
              state <= S_SG4;
            end else begin
              kk <= kk + 1'b1;
            end
          end
        end
        S_SG4: begin
          if (div_done) begin
            score <= (div_q[NUM_W-1:16] != '0) ? 16'hFFFF : div_q[15:0];
            state <= S_CHK;
          end
        end
        S_CHK: begin
          dsel <= 2'd0;
          state <= (score >= score_thr) ? S_DCM : S_FE;
        end
        S_DCM: state <= S_DCD;
        S_DCD: begin
          if (div_done) begin
            dq[dsel] <= dlt[dsel][19] ? -dq_mag : dq_mag;
            if (dsel == 2'd3) begin
              state <= S_GEOM;
            end else begin
              dsel <= dsel + 1'b1;
              state <= S_DCM;
            end
          end
        end
        S_GEOM: begin
          nb.l <= lc[16:0];
          nb.t <= tc[16:0];
          nb.w <= wv[16:0];
          nb.h <= hv[16:0];
          nb.s <= score;
          state <= box_ok ? S_INS0 : S_FE;
        end
        S_INS0: begin
          if (count < CAND_FULL) begin
            kidx <= count[AW-1:0];
            count <= count + 1'b1;
            state <= S_INSR;
          end else begin
            ovf <= 1'b1;
            state <= S_INSF;
          end
        end
        S_INSF: begin
          if (rd_q.s >= nb.s) begin
            state <= S_FE;
          end else begin
            kidx <= LAST_ADDR;
            state <= S_INSR;
          end
        end
        S_INSR: state <= (kidx == '0) ? S_FE : S_INSC;
        S_INSC: begin
          if (rd_q.s >= nb.s) begin
            state <= S_FE;
          end else begin
            kidx <= kidx - 1'b1;
            state <= S_INSR;
          end
        end
        S_FE: begin
          ii <= '0;
          nout <= 7'd0;
          priority if (!fend) begin
            state <= S_IDLE;
          end else if (count == '0) begin
            state <= S_FIN;
          end else begin
            state <= S_NMI;
          end
        end
        S_NMI: begin
          priority if ((ii >= count) || (nout >= limit)) begin
            state <= S_FIN;
          end else if (mask[ii[AW-1:0]]) begin
            ii <= ii + 1'b1;
          end else begin
            mask[ii[AW-1:0]] <= 1'b1;
            state <= S_NML;
          end
        end
        S_NML: begin
          lead <= rd_q;
          cur <= rd_q;
          sums[0] <= '0;
          sums[1] <= '0;
          sums[2] <= '0;
          sums[3] <= '0;
          sw <= '0;
          jj <= ii + 1'b1;
          csel <= 2'd0;
          state <= S_NMAR;
        end
        S_NMAR: begin
          area_a <= mul_p[32:0];
          state <= S_ACCM;
        end
        S_ACCM: state <= S_ACCA;
        S_ACCA: begin
          sums[csel] <= sums[csel] + SUM_W'(mul_p[32:0]);
          if (csel == 2'd3) begin
            sw <= sw + SW_W'(cur.s);
            state <= S_NMJ;
          end else begin
            csel <= csel + 1'b1;
            state <= S_ACCM;
          end
        end
        S_NMJ: begin
          priority if (jj >= count) begin
            state <= S_NMO;
          end else if (mask[jj[AW-1:0]]) begin
            jj <= jj + 1'b1;
          end else begin
            state <= S_NMB;
          end
        end
        S_NMB: begin
          cur <= rd_q;
          state <= S_NMB1;
        end
        S_NMB1: begin
          area_b <= mul_p[32:0];
          state <= S_NMB2;
        end
        S_NMB2: begin
          inter <= mul_p[34:0];
          uni <= uni_w[33:0];
          state <= S_NMB3;
        end
        S_NMB3: begin
          jj <= jj + 1'b1;
          if (merge) begin
            mask[jj[AW-1:0]] <= 1'b1;
            csel <= 2'd0;
            state <= S_ACCM;
          end else begin
            state <= S_NMJ;
          end
        end
        S_NMO: begin
          res.s <= lead.s;
          csel <= 2'd0;
          if (sw == '0) begin
            res.l <= lead.l;
            res.t <= lead.t;
            res.w <= lead.w;
            res.h <= lead.h;
            state <= S_NMP;
          end else begin
            state <= S_NMDV;
          end
        end
        S_NMDV: begin
          if (div_done) begin
            unique case (csel)
              2'd0: res.l <= div_q[16:0];
              2'd1: res.t <= div_q[16:0];
              2'd2: res.w <= div_q[16:0];
              default: res.h <= div_q[16:0];
            endcase
            if (csel == 2'd3) begin
              state <= S_NMP;
            end else begin
              csel <= csel + 1'b1;
            end
          end
        end
        S_NMP: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              box_x <= pend.l;
              box_y <= pend.t;
              box_w <= pend.w;
              box_h <= pend.h;
              peak_score <= pend.s;
              last_box <= 1'b0;
              empty_frame <= 1'b0;
              overflow <= ovf;
            end
            pend <= res;
            pend_v <= 1'b1;
            nout <= nout + 1'b1;
            ii <= ii + 1'b1;
            state <= S_NMI;
          end
        end
        S_FIN: begin
          if (out_free) begin
            last_box <= 1'b1;
            if (pend_v) begin
              box_x <= pend.l;
              box_y <= pend.t;
              box_w <= pend.w;
              box_h <= pend.h;
              peak_score <= pend.s;
              empty_frame <= 1'b0;
              overflow <= ovf;
            end else begin
              box_x <= '0;
              box_y <= '0;
              box_w <= '0;
              box_h <= '0;
              peak_score <= '0;
              empty_frame <= 1'b1;
              overflow <= 1'b0;
            end
            pend_v <= 1'b0;
            count <= '0;
            ovf <= 1'b0;
            mask <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
